/* hdl/mfmd_pkg.sv */
// Shared widths, codes and types of the multi-turn motor feedback decoder.
package mfmd_pkg;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 120;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int CNT_W   = 32;
  localparam int Q10_W   = 36;
  localparam int WHOLE_W = 32;
  localparam int PROD_W  = 38;

  localparam logic OP_FEEDBACK = 1'b0;
  localparam logic OP_CAPTURE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_DEADBAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_JUMP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MIDPOINT  = 2'd2;

  localparam logic [3:0] DATA_FRAME_LEN = 4'd8;
  localparam int         TURN_SHIFT     = 13;

  typedef struct packed {
    logic [Q10_W-1:0]   q10;
    logic [WHOLE_W-1:0] whole;
  } scale_t;

endpackage

/* hdl/motor_feedback_multiturn_decoder_top.sv */
// Top level of the multi-turn motor feedback decoder.
//
//  Channel   | Signals                              | Direction | Carries
//  ----------+--------------------------------------+-----------+---------------------------
//  s_*       | s_tvalid s_tready s_tdata s_tuser    | in        | feedback frame or capture
//  m_*       | m_tvalid m_tready m_tdata m_tuser    | out       | decoded position word
//  cfg_*     | cfg_we cfg_index cfg_data            | in        | register writes
//
// Each word passes three registers: the input register, a middle register fed by
// the logic that reads and updates the per-motor state and forms the relative
// count, and the output register fed by the logic that scales the count to
// degrees. One word is accepted every cycle while the output is not stalled; the
// per-motor state update is the loop that sets this rate. Each stage moves on
// when the stage after it is empty or moving, so bubbles are squeezed out and
// input is still taken while a finished word waits at the output, until the two
// earlier stages are full.
// Reset (rst, synchronous) empties the pipeline, clears all per-motor state and
// loads the register defaults.
module motor_feedback_multiturn_decoder_top #(
  parameter int MOTORS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // frame_id[10:0] is_extended[11] is_remote[12] frame_length[16:13]
  // angle_high[24:17] angle_low[32:25] speed_high[40:33] speed_low[48:41]
  input  logic [mfmd_pkg::IN_TDATA_W-1:0]     s_tdata,
  // op[0]
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // motor_slot[1:0] speed_rpm[17:2] position_counts[49:18]
  // angle_deg_q10[85:50] angle_deg_whole[117:86]
  output logic [mfmd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // accepted[0]
  output logic [0:0]                          m_tuser,
  input  logic                                cfg_we,
  input  logic [mfmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mfmd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mfmd_pkg::*;

  localparam int SLOT_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  // Configuration registers.
  logic [7:0]  speed_deadband;
  logic [15:0] wrap_jump;
  logic [15:0] wrap_midpoint;

  // Per-motor state, small enough to live in flip-flops.
  logic [15:0]      last_raw   [MOTORS];
  logic [15:0]      turn_count [MOTORS];
  logic [CNT_W-1:0] zero_offset[MOTORS];
  logic [CNT_W-1:0] cur_pos    [MOTORS];

  // Input register.
  logic                  s1_valid;
  logic                  s1_op;
  logic [IN_TDATA_W-1:0] s1_data;

  // Middle stage.
  logic             s2_valid;
  logic             s2_acc;
  logic [1:0]       s2_slot;
  logic [15:0]      s2_speed;
  logic [CNT_W-1:0] s2_counts;

  // Output register.
  logic             out_valid;
  logic             out_acc;
  logic [1:0]       out_slot;
  logic [15:0]      out_speed;
  logic [CNT_W-1:0] out_counts;
  scale_t           out_scaled;
  scale_t           scaled;

  logic out_en;
  logic s2_en;
  logic s1_en;

  assign out_en   = !out_valid || m_tready;
  assign s2_en    = !s2_valid || out_en;
  assign s1_en    = !s1_valid || s2_en;
  assign s_tready = s1_en;

  // Field decode of the registered input word.
  logic [10:0] frame_id;
  logic        is_extended;
  logic        is_remote;
  logic [3:0]  frame_length;
  logic [15:0] raw;
  logic [15:0] spd;

  assign frame_id     = s1_data[10:0];
  assign is_extended  = s1_data[11];
  assign is_remote    = s1_data[12];
  assign frame_length = s1_data[16:13];
  assign raw          = {s1_data[24:17], s1_data[32:25]};
  assign spd          = {s1_data[40:33], s1_data[48:41]};

  logic [3:0]        motor_num;
  logic [3:0]        slot4;
  logic [SLOT_W-1:0] sidx;
  logic              frame_hit;
  logic              step;

  assign motor_num = frame_id[3:0];
  assign slot4     = motor_num - 4'd1;
  assign sidx      = slot4[SLOT_W-1:0];
  assign frame_hit = (s1_op == OP_FEEDBACK) && !is_extended && !is_remote &&
                     (frame_length == DATA_FRAME_LEN) && (motor_num != 4'd0) &&
                     ({28'd0, motor_num} <= 32'(MOTORS));
  assign step      = s1_valid && s2_en;

  // Speed deadband on the magnitude; the most negative speed has magnitude 32768.
  logic [15:0] spd_mag;
  logic [15:0] speed_out;

  assign spd_mag   = spd[15] ? (~spd + 16'd1) : spd;
  assign speed_out = (spd_mag <= {8'd0, speed_deadband}) ? 16'd0 : spd;

  // Wrap detection against the last angle of this motor.
  logic [15:0]      last;
  logic [15:0]      turn;
  logic [16:0]      diff;
  logic [16:0]      diff_abs;
  logic             wrapped;
  logic [15:0]      turn_next;
  logic [CNT_W-1:0] pos_next;
  logic [CNT_W-1:0] rel;

  assign last     = last_raw[sidx];
  assign turn     = turn_count[sidx];
  assign diff     = {1'b0, raw} - {1'b0, last};
  assign diff_abs = diff[16] ? (~diff + 17'd1) : diff;
  assign wrapped  = diff_abs > {1'b0, wrap_jump};

  always_comb begin
    if (!wrapped) begin
      turn_next = turn;
    end else if (last > wrap_midpoint) begin
      turn_next = turn + 16'd1;
    end else begin
      turn_next = turn - 16'd1;
    end
  end

  assign pos_next = ({{(CNT_W-16){turn_next[15]}}, turn_next} << TURN_SHIFT) +
                    {{(CNT_W-16){1'b0}}, raw};
  assign rel      = pos_next - zero_offset[sidx];

  // Configuration writes; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_deadband <= 8'd3;
      wrap_jump      <= 16'd6000;
      wrap_midpoint  <= 16'd4000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPEED_DEADBAND: speed_deadband <= cfg_data[7:0];
        REG_WRAP_JUMP:      wrap_jump      <= cfg_data;
        REG_WRAP_MIDPOINT:  wrap_midpoint  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-motor state update as the word leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        last_raw[i]    <= '0;
        turn_count[i]  <= '0;
        zero_offset[i] <= '0;
        cur_pos[i]     <= '0;
      end
    end else if (step) begin
      if (s1_op == OP_CAPTURE) begin
        for (int i = 0; i < MOTORS; i++) begin
          zero_offset[i] <= cur_pos[i];
        end
      end else if (frame_hit) begin
        last_raw[sidx]   <= raw;
        turn_count[sidx] <= turn_next;
        cur_pos[sidx]    <= pos_next;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && s_tvalid) begin
      s1_op   <= s_tuser[0];
      s1_data <= s_tdata;
    end
  end

  // Middle stage; ignored frames and captures carry all-zero fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s2_acc    <= frame_hit;
      s2_slot   <= frame_hit ? slot4[1:0] : 2'd0;
      s2_speed  <= frame_hit ? speed_out : 16'd0;
      s2_counts <= frame_hit ? rel : '0;
    end
  end

  mfmd_scale u_scale (
    .counts (s2_counts),
    .scaled (scaled)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s2_valid) begin
      out_acc    <= s2_acc;
      out_slot   <= s2_slot;
      out_speed  <= s2_speed;
      out_counts <= s2_counts;
      out_scaled <= scaled;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tuser[0] = out_acc;
  assign m_tdata    = {2'b00, out_scaled.whole, out_scaled.q10, out_counts, out_speed, out_slot};

  // The input side never waits while the output register is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output register");

  // A word that did not update a motor carries only zeros.
  a_rejected_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("rejected word carries nonzero fields");

  // A capture takes each motor's absolute position as its zero; checked for motor one.
  a_capture_zero: assert property (@(posedge clk) disable iff (rst)
    (step && (s1_op == OP_CAPTURE)) |=> (zero_offset[0] == $past(cur_pos[0])))
    else $error("capture did not load the zero offset");

  // A valid frame reaches the middle stage marked as accepted.
  a_hit_accepted: assert property (@(posedge clk) disable iff (rst)
    (step && frame_hit) |=> (s2_valid && s2_acc))
    else $error("valid frame lost its accepted mark");

endmodule

/* hdl/mfmd_scale.sv */
// Converts a signed position count into saturated Q10 degrees and whole degrees.
module mfmd_scale (
  input  logic [mfmd_pkg::CNT_W-1:0] counts,
  output mfmd_pkg::scale_t           scaled
);
  import mfmd_pkg::*;

  logic [PROD_W-1:0] cext;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] biased;
  logic              sat;

  // Times 45 as 32 + 8 + 4 + 1; the product always fits in 38 bits.
  assign cext = {{(PROD_W-CNT_W){counts[CNT_W-1]}}, counts};
  assign prod = (cext << 5) + (cext << 3) + (cext << 2) + cext;

  // Out of the 36-bit range when the top three bits disagree.
  assign sat = !((prod[PROD_W-1:Q10_W-1] == '0) || (prod[PROD_W-1:Q10_W-1] == '1));

  // Arithmetic shift rounds toward minus infinity, so bias negatives first.
  assign biased = prod + (prod[PROD_W-1] ? PROD_W'(1023) : PROD_W'(0));

  always_comb begin
    if (sat) begin
      scaled.q10 = prod[PROD_W-1] ? {1'b1, {(Q10_W-1){1'b0}}} : {1'b0, {(Q10_W-1){1'b1}}};
    end else begin
      scaled.q10 = prod[Q10_W-1:0];
    end
    // The quotient needs only 28 bits; sign-extend it to the full width.
    scaled.whole = {{(WHOLE_W-PROD_W+10){biased[PROD_W-1]}}, biased[PROD_W-1:10]};
  end

endmodule
